// ===== design/b64sd_pkg.sv =====
// Package with the alphabet decode, status codes and sextet lookup type of the base64 decoder.
package b64sd_pkg;

    // End-of-message status codes.
    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_BAD_LEN  = 3'd1;
    localparam logic [2:0] STAT_BAD_PAD  = 3'd2;
    localparam logic [2:0] STAT_BAD_CHAR = 3'd3;
    localparam logic [2:0] STAT_PAD_BITS = 3'd4;

    // The padding character '='.
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Sextet lookup result: invalid flag and 6-bit value.
    typedef struct packed {
        logic       invalid;
        logic [5:0] value;
    } sextet_t;

    // Maps one character of the standard alphabet to its sextet.
    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t r;
        logic [7:0] t;
        r = '{invalid: 1'b0, value: 6'd0};
        t = 8'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            t = c - 8'd65;
        end else if (c inside {[8'h61:8'h7A]}) begin
            t = c - 8'd71;
        end else if (c inside {[8'h30:8'h39]}) begin
            t = c + 8'd4;
        end else if (c == 8'h2B) begin
            t = 8'd62;
        end else if (c == 8'h2F) begin
            t = 8'd63;
        end else begin
            r.invalid = 1'b1;
        end
        r.value = t[5:0];
        return r;
    endfunction

endpackage

// ===== design/base64_strict_decoder.sv =====
// Top level of the strict base64 decoder: character decode, group checks and result drain.
// A result beat is offered in the cycle after the character that causes it is accepted.
// One character per cycle unless stalled; a bundle register drains one beat per cycle unless held.
// A character that completes a group or ends a message stalls only while the previous
// bundle (up to three bytes and a status) is still draining; with every beat taken, groups
// of four never wait, while a short message right after a four-beat bundle may have to wait.
// Reset: asynchronous, active low; clears group state, error state and the result bundle.
module base64_strict_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    input  logic [7:0] ch,
    input  logic       final_char,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] data_byte,
    output logic       is_status,
    output logic [2:0] status,
    output logic       run_end
);
    import b64sd_pkg::*;

    // Group and message state.
    logic [1:0]  group_pos_reg, group_pos_next;
    logic [17:0] sextet_acc_reg, sextet_acc_next;
    logic        third_was_pad_reg, third_was_pad_next;
    logic        bad_char_reg, bad_char_next;
    logic [2:0]  error_code_reg, error_code_next;

    // Result bundle: up to three bytes followed by an optional status beat.
    logic        bundle_valid_reg;
    logic [1:0]  beat_idx_reg;
    logic [1:0]  last_idx_reg;
    logic [1:0]  n_bytes_reg;
    logic        has_status_reg;
    logic [2:0]  status_reg;
    logic [7:0]  byte_reg [3];

    // Values computed for the beat being accepted.
    sextet_t     sx;
    logic        is_pad;
    logic        produces;
    logic [1:0]  n_bytes_new;
    logic        has_status_new;
    logic [2:0]  status_new;
    logic [23:0] group_value;
    logic        src_acc;
    logic        res_take;
    logic        last_take;

    assign sx     = sextet_of(ch);
    assign is_pad = (ch == PAD_CHAR);
    assign group_value = {sextet_acc_reg, (is_pad ? 6'd0 : sx.value)};

    // Only a fourth character or a final character can create results.
    assign produces  = final_char || (group_pos_reg == 2'd3);
    assign src_stall = bundle_valid_reg && !last_take && produces;
    assign src_acc   = src_valid && !src_stall;
    assign res_take  = bundle_valid_reg && !res_stall;
    assign last_take = res_take && (beat_idx_reg == last_idx_reg);

    // Decode one character and update the group state.
    always_comb
    begin
        logic       bad_all;
        logic       fourth_pad;
        logic [5:0] second_sx;
        logic [5:0] third_sx;

        bad_all    = 1'b0;
        fourth_pad = 1'b0;
        second_sx  = sextet_acc_reg[11:6];
        third_sx   = sextet_acc_reg[5:0];

        group_pos_next     = group_pos_reg;
        sextet_acc_next    = sextet_acc_reg;
        third_was_pad_next = third_was_pad_reg;
        bad_char_next      = bad_char_reg;
        error_code_next    = error_code_reg;
        n_bytes_new        = 2'd0;
        has_status_new     = 1'b0;
        status_new         = STAT_OK;

        if (group_pos_reg != 2'd3) begin
            if (group_pos_reg == 2'd2 && is_pad) begin
                third_was_pad_next = 1'b1;
                sextet_acc_next    = {sextet_acc_reg[11:0], 6'd0};
            end else begin
                bad_char_next   = bad_char_reg | sx.invalid;
                sextet_acc_next = {sextet_acc_reg[11:0],
                                   (sx.invalid ? 6'd0 : sx.value)};
            end
            group_pos_next = group_pos_reg + 2'd1;
        end else begin
            fourth_pad = is_pad;
            bad_all    = bad_char_reg | (!fourth_pad && sx.invalid);
            if (error_code_reg == STAT_OK) begin
                if ((third_was_pad_reg && !fourth_pad) ||
                    ((third_was_pad_reg || fourth_pad) && !final_char)) begin
                    error_code_next = STAT_BAD_PAD;
                end else if (bad_all) begin
                    error_code_next = STAT_BAD_CHAR;
                end else if ((third_was_pad_reg && second_sx[3:0] != 4'd0) ||
                             (fourth_pad && !third_was_pad_reg &&
                              third_sx[1:0] != 2'd0)) begin
                    error_code_next = STAT_PAD_BITS;
                end else begin
                    // A padded third place implies a padded fourth place here.
                    n_bytes_new = 2'd1 + {1'b0, !third_was_pad_reg}
                                + {1'b0, !fourth_pad};
                end
            end
            group_pos_next     = 2'd0;
            sextet_acc_next    = '0;
            third_was_pad_next = 1'b0;
            bad_char_next      = 1'b0;
        end

        // The final character closes the message with a status beat.
        if (final_char) begin
            has_status_new     = 1'b1;
            status_new         = (group_pos_reg != 2'd3) ? STAT_BAD_LEN : error_code_next;
            group_pos_next     = 2'd0;
            sextet_acc_next    = '0;
            third_was_pad_next = 1'b0;
            bad_char_next      = 1'b0;
            error_code_next    = STAT_OK;
        end
    end

    // Control state and the bundle bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            group_pos_reg     <= 2'd0;
            sextet_acc_reg    <= '0;
            third_was_pad_reg <= 1'b0;
            bad_char_reg      <= 1'b0;
            error_code_reg    <= STAT_OK;
            bundle_valid_reg  <= 1'b0;
            beat_idx_reg      <= 2'd0;
            last_idx_reg      <= 2'd0;
            n_bytes_reg       <= 2'd0;
            has_status_reg    <= 1'b0;
            status_reg        <= STAT_OK;
        end else begin
            if (src_acc) begin
                group_pos_reg     <= group_pos_next;
                sextet_acc_reg    <= sextet_acc_next;
                third_was_pad_reg <= third_was_pad_next;
                bad_char_reg      <= bad_char_next;
                error_code_reg    <= error_code_next;
            end
            if (src_acc && (n_bytes_new != 2'd0 || has_status_new)) begin
                bundle_valid_reg <= 1'b1;
                beat_idx_reg     <= 2'd0;
                last_idx_reg     <= n_bytes_new + {1'b0, has_status_new} - 2'd1;
                n_bytes_reg      <= n_bytes_new;
                has_status_reg   <= has_status_new;
                status_reg       <= status_new;
            end else if (last_take) begin
                bundle_valid_reg <= 1'b0;
            end else if (res_take) begin
                beat_idx_reg <= beat_idx_reg + 2'd1;
            end
        end
    end

    // Decoded bytes of the bundle; no reset needed.
    always_ff @(posedge clk)
    begin
        if (src_acc && n_bytes_new != 2'd0) begin
            byte_reg[0] <= group_value[23:16];
            byte_reg[1] <= group_value[15:8];
            byte_reg[2] <= group_value[7:0];
        end
    end

    // Present the current beat of the bundle.
    always_comb
    begin
        res_valid = bundle_valid_reg;
        run_end   = (beat_idx_reg == last_idx_reg);
        if (beat_idx_reg < n_bytes_reg) begin
            data_byte = byte_reg[beat_idx_reg];
            is_status = 1'b0;
            status    = STAT_OK;
        end else begin
            data_byte = 8'd0;
            is_status = has_status_reg;
            status    = status_reg;
        end
    end

`ifndef SYNTH
    // A final character always leaves a bundle to drain.
    a_final_loads: assert property (@(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall && final_char |=> res_valid)
        else $error("final character did not produce a result bundle");

    // The status beat is always the last beat of its bundle.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && is_status |-> run_end)
        else $error("status beat is not the last beat");

    // With no bundle pending the input side is never held off.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !src_stall)
        else $error("input stalled while no result is pending");
`endif

endmodule

// ===== bench/base64_strict_decoder_test.sv =====
// Self-checking testbench for the strict base64 decoder: directed table, random messages, beat checks.
module base64_strict_decoder_test;
    import b64sd_pkg::*;

    // One result beat as the block presents it.
    typedef struct packed {
        logic [7:0] data;
        logic       is_st;
        logic [2:0] st;
        logic       last;
    } beat_t;

    // One row of the directed table; a typed row carries the status to expect.
    typedef struct packed {
        logic [7:0] c;
        logic       fin;
        logic       typed;
        logic [2:0] want;
    } stim_row_t;

    localparam int  N_DIRECTED = 29;
    localparam logic FREE      = 1'b0;
    localparam logic TYPED     = 1'b1;

    logic       clk;
    logic       rst_n;
    logic       src_valid;
    logic       src_stall;
    logic [7:0] ch;
    logic       final_char;
    logic       res_valid;
    logic       res_stall;
    logic [7:0] data_byte;
    logic       is_status;
    logic [2:0] status;
    logic       run_end;

    // Decoder state as the bench tracks it.
    logic [1:0]  grp_pos;
    logic [17:0] acc;
    logic        pad3;
    logic        bad_seen;
    logic [2:0]  msg_err;

    beat_t     expected_beats [$];
    stim_row_t directed_rows [0:N_DIRECTED-1];
    int        errors = 0;
    logic      idling;

    base64_strict_decoder dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .ch         (ch),
        .final_char (final_char),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .data_byte  (data_byte),
        .is_status  (is_status),
        .status     (status),
        .run_end    (run_end)
    );

    // Character of the standard alphabet for a sextet value.
    function automatic logic [7:0] char_of(input logic [5:0] v);
        if (v < 6'd26)
        begin
            return "A" + v;
        end
        if (v < 6'd52)
        begin
            return "a" - 8'd26 + v;
        end
        if (v < 6'd62)
        begin
            return "0" - 8'd52 + v;
        end
        return (v == 6'd62) ? "+" : "/";
    endfunction

    // Found flag and sextet value of a character.
    function automatic logic [6:0] sextet_lookup(input logic [7:0] c);
        for (int i = 0; i < 64; i++)
        begin
            if (char_of(i[5:0]) == c)
            begin
                return {1'b1, i[5:0]};
            end
        end
        return 7'd0;
    endfunction

    function automatic void clear_group();
        grp_pos  = 2'd0;
        acc      = 18'd0;
        pad3     = 1'b0;
        bad_seen = 1'b0;
    endfunction

    // Works out the beats that one accepted character causes and queues them.
    function automatic void predict_char(input logic [7:0] c, input logic fin,
                                         input logic typed, input logic [2:0] want);
        beat_t       outb [0:3];
        int          n;
        logic [1:0]  pos;
        logic [6:0]  hit;
        logic [5:0]  v;
        logic        pad4;
        logic [23:0] word;
        logic [2:0]  st;
        n   = 0;
        pos = grp_pos;
        v   = 6'd0;
        if (pos != 2'd3)
        begin
            // First three places gather sextets; '=' only counts as padding in the third.
            if (pos == 2'd2 && c == PAD_CHAR)
            begin
                pad3 = 1'b1;
            end
            else
            begin
                hit = sextet_lookup(c);
                if (!hit[6])
                begin
                    bad_seen = 1'b1;
                end
                v = hit[6] ? hit[5:0] : 6'd0;
            end
            acc     = {acc[11:0], v};
            grp_pos = pos + 2'd1;
        end
        else
        begin
            pad4 = (c == PAD_CHAR);
            if (!pad4)
            begin
                hit = sextet_lookup(c);
                if (!hit[6])
                begin
                    bad_seen = 1'b1;
                end
                v = hit[6] ? hit[5:0] : 6'd0;
            end
            // Group checks run only until the first error of the message.
            if (msg_err == STAT_OK)
            begin
                if ((pad3 && !pad4) || ((pad3 || pad4) && !fin))
                begin
                    msg_err = STAT_BAD_PAD;
                end
                else if (bad_seen)
                begin
                    msg_err = STAT_BAD_CHAR;
                end
                else if ((pad3 && acc[9:6] != 4'd0) || (pad4 && !pad3 && acc[1:0] != 2'd0))
                begin
                    msg_err = STAT_PAD_BITS;
                end
                else
                begin
                    word = {acc, v};
                    outb[n] = {word[23:16], 1'b0, STAT_OK, 1'b0};
                    n++;
                    if (!pad3)
                    begin
                        outb[n] = {word[15:8], 1'b0, STAT_OK, 1'b0};
                        n++;
                    end
                    if (!pad4)
                    begin
                        outb[n] = {word[7:0], 1'b0, STAT_OK, 1'b0};
                        n++;
                    end
                end
            end
            clear_group();
        end
        // End of message: a short last group outranks any earlier error.
        if (fin)
        begin
            st = (pos != 2'd3) ? STAT_BAD_LEN : msg_err;
            if (typed)
            begin
                st = want;
            end
            outb[n] = {8'd0, 1'b1, st, 1'b0};
            n++;
            clear_group();
            msg_err = STAT_OK;
        end
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
            begin
                outb[i].last = 1'b1;
            end
            expected_beats = {expected_beats, outb[i]};
        end
    endfunction

    // Offers one character beat, with random gaps, and predicts it once accepted.
    task automatic send_char(input logic [7:0] c, input logic fin,
                             input logic typed, input logic [2:0] want);
        while (idling && $urandom_range(99) < 37)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid  <= 1'b1;
        ch         <= c;
        final_char <= fin;
        @(posedge clk);
        while (src_stall)
        begin
            @(posedge clk);
        end
        predict_char(c, fin, typed, want);
        @(negedge clk);
    endtask

    // Sends one random message: mostly well formed, sometimes damaged.
    task automatic send_message(output int count);
        logic [7:0] msg [$];
        int         groups;
        int         kind;
        int         pads;
        groups = $urandom_range(1, 3);
        kind   = $urandom_range(11);
        pads   = (kind == 10) ? $urandom_range(1, 2) : $urandom_range(2);
        for (int i = 0; i < groups * 4; i++)
        begin
            msg = {msg, char_of(6'($urandom_range(63)))};
        end
        // Proper padding leaves the unused bits zero, except for the pad-bit damage kind.
        if (pads == 2)
        begin
            msg[msg.size() - 1] = PAD_CHAR;
            msg[msg.size() - 2] = PAD_CHAR;
            if (kind != 10)
            begin
                msg[msg.size() - 3] = char_of(6'(16 * $urandom_range(3)));
            end
        end
        else if (pads == 1)
        begin
            msg[msg.size() - 1] = PAD_CHAR;
            if (kind != 10)
            begin
                msg[msg.size() - 2] = char_of(6'(4 * $urandom_range(15)));
            end
        end
        // Damage kinds: stray byte, misplaced pad, cut short, one character too many.
        case (kind)
            7: msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
            8: msg[$urandom_range(msg.size() - 1)] = PAD_CHAR;
            9:
            begin
                repeat ($urandom_range(1, 3))
                begin
                    if (msg.size() > 1)
                    begin
                        msg.delete(msg.size() - 1);
                    end
                end
            end
            11: msg = {msg, char_of(6'($urandom_range(63)))};
            default: ;
        endcase
        for (int i = 0; i < msg.size(); i++)
        begin
            send_char(msg[i], i == msg.size() - 1, FREE, STAT_OK);
        end
        count = msg.size();
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Consumer side: random stall, changed at the falling edge.
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            res_stall <= idling && ($urandom_range(99) < 37);
        end
    end

    // Compare every accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin : check_beats
        beat_t got;
        beat_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            got = {data_byte, is_status, status, run_end};
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected beat data=%h is_status=%b status=%0d run_end=%b",
                         $time, got.data, got.is_st, got.st, got.last);
                errors++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got !== want)
                begin
                    $display("%0t: expected data=%h is_status=%b status=%0d run_end=%b,",
                             $time, want.data, want.is_st, want.st, want.last,
                             " got data=%h is_status=%b status=%0d run_end=%b",
                             got.data, got.is_st, got.st, got.last);
                    errors++;
                end
            end
        end
    end

    // Main stimulus: reset, directed table, random messages, drain.
    initial
    begin : stimulus
        int sent;
        int n;
        rst_n      = 1'b0;
        src_valid  = 1'b0;
        ch         = 8'd0;
        final_char = 1'b0;
        idling     = 1'b1;
        msg_err    = STAT_OK;
        clear_group();
        // Directed messages: byte extremes, the double pad form, each error and its priority.
        directed_rows = '{
            {"/", 1'b0, FREE, STAT_OK}, {"/", 1'b0, FREE, STAT_OK},
            {"/", 1'b0, FREE, STAT_OK}, {"/", 1'b1, TYPED, STAT_OK},
            {"Q", 1'b0, FREE, STAT_OK}, {"Q", 1'b0, FREE, STAT_OK},
            {PAD_CHAR, 1'b0, FREE, STAT_OK}, {PAD_CHAR, 1'b1, TYPED, STAT_OK},
            {"Q", 1'b0, FREE, STAT_OK}, {"R", 1'b0, FREE, STAT_OK},
            {PAD_CHAR, 1'b0, FREE, STAT_OK}, {PAD_CHAR, 1'b1, TYPED, STAT_PAD_BITS},
            {"A", 1'b0, FREE, STAT_OK}, {"A", 1'b0, FREE, STAT_OK},
            {PAD_CHAR, 1'b0, FREE, STAT_OK}, {"A", 1'b1, TYPED, STAT_BAD_PAD},
            {PAD_CHAR, 1'b0, FREE, STAT_OK}, {"A", 1'b0, FREE, STAT_OK},
            {"A", 1'b0, FREE, STAT_OK}, {"A", 1'b0, FREE, STAT_OK},
            {"A", 1'b0, FREE, STAT_OK}, {"B", 1'b0, FREE, STAT_OK},
            {PAD_CHAR, 1'b0, FREE, STAT_OK}, {PAD_CHAR, 1'b1, TYPED, STAT_BAD_CHAR},
            {8'h00, 1'b0, FREE, STAT_OK}, {"A", 1'b0, FREE, STAT_OK},
            {PAD_CHAR, 1'b0, FREE, STAT_OK}, {PAD_CHAR, 1'b0, FREE, STAT_OK},
            {8'hFF, 1'b1, TYPED, STAT_BAD_LEN}
        };
        repeat (6)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_char(directed_rows[i].c, directed_rows[i].fin,
                      directed_rows[i].typed, directed_rows[i].want);
        end
        // Random messages, with a stretch in the middle where neither side idles.
        sent = 0;
        while (sent < 100)
        begin
            idling <= !(sent >= 30 && sent < 70);
            send_message(n);
            sent += n;
        end
        src_valid <= 1'b0;
        idling    <= 1'b1;
        while (expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10)
        begin
            @(posedge clk);
        end
        if (errors == 0)
        begin
            $display("base64_strict_decoder_test: clean");
        end
        else
        begin
            $display("base64_strict_decoder_test: errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("base64_strict_decoder_test: errors");
        $finish;
    end

endmodule
